// ===== design/css_pkg.sv =====
`default_nettype none

package css_pkg;

    localparam int unsigned TargetWidth = 12;
    localparam int unsigned DelayWidth  = 16;
    localparam int unsigned StepWidth   = 8;
    localparam int unsigned RefWidth    = 16;
    localparam int unsigned CfgIdxWidth = 8;
    localparam int unsigned CfgValWidth = 16;

    typedef enum logic [2:0] {
        PH_INIT       = 3'd0,
        PH_LAUNCH     = 3'd1,
        PH_STANDBY    = 3'd2,
        PH_ON_DELAY   = 3'd3,
        PH_RAMP       = 3'd4,
        PH_GOOD_DELAY = 3'd5,
        PH_COMPLETE   = 3'd6,
        PH_FAULT      = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_STANDBY = 3'd1,
        ST_START   = 3'd2,
        ST_ON      = 3'd3,
        ST_FAULT   = 3'd4
    } status_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_POWER_ON_DELAY   = 8'd0,
        REG_POWER_GOOD_DELAY = 8'd1,
        REG_RAMP_STEP        = 8'd2,
        REG_SELF_START       = 8'd3
    } cfg_reg_t;

    localparam logic [DelayWidth-1:0] PowerOnDelayReset   = 16'd500;
    localparam logic [DelayWidth-1:0] PowerGoodDelayReset = 16'd200;
    localparam logic [StepWidth-1:0]  RampStepReset       = 8'd4;

    typedef struct packed {
        logic [TargetWidth-1:0] target_reference;
        logic                   enable_request;
        logic                   go_request;
        logic                   adc_sample_seen;
        logic                   fault_clear;
        logic                   fault_request;
    } tick_in_t;

    typedef struct packed {
        logic [2:0]          run_status;
        logic [2:0]          phase_now;
        logic                pwm_output_enable;
        logic                loop_enable;
        logic                use_soft_reference;
        logic [RefWidth-1:0] soft_reference;
        logic                fault_latched;
    } tick_out_t;

    typedef struct packed {
        logic [CfgIdxWidth-1:0] index;
        logic [CfgValWidth-1:0] value;
    } cfg_write_t;

endpackage

`default_nettype wire

// ===== design/css_stream_if.sv =====
`default_nettype none

interface css_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/converter_soft_start_sequencer.sv =====
// latency: the result of an item is valid in the cycle after the item is accepted
// throughput: one item per cycle; the single output register is refilled while its
// current result is being taken, so input stalls only when the output is stalled
// reset (rst_n low, asynchronous): phase init, counter, soft reference and all flags
// zero; power_on_delay 500, power_good_delay 200, ramp_step 4, self start 0
`default_nettype none

module converter_soft_start_sequencer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    css_stream_if.sink   in,
    css_stream_if.source out,
    css_stream_if.sink   cfg
);

    // configuration
    logic [css_pkg::DelayWidth-1:0] power_on_delay_reg;
    logic [css_pkg::DelayWidth-1:0] power_good_delay_reg;
    logic [css_pkg::StepWidth-1:0]  ramp_step_reg;
    logic                           self_start_reg;

    // sequencer state
    css_pkg::phase_t                phase_reg, phase_next;
    logic [css_pkg::DelayWidth-1:0] tick_counter_reg, tick_counter_next;
    logic [css_pkg::RefWidth-1:0]   ramp_reference_reg, ramp_reference_next;
    logic                           fault_flag_reg, fault_flag_next;
    logic                           adc_active_reg, adc_active_next;
    logic                           pwm_drive_reg, pwm_drive_next;
    logic                           loop_on_reg, loop_on_next;
    logic                           ref_select_reg, ref_select_next;

    // output register
    logic                 out_valid_reg;
    css_pkg::tick_out_t   out_data_reg, out_data_next;

    css_pkg::tick_in_t              item;
    logic                           in_accept;
    logic                           enable;
    logic                           go;
    css_pkg::phase_t                phase_cur;
    css_pkg::status_t               status;
    logic [css_pkg::DelayWidth-1:0] count_inc;
    logic [css_pkg::RefWidth:0]     ramp_sum;
    logic [css_pkg::RefWidth-1:0]   ramp_sat;
    logic [css_pkg::DelayWidth-1:0] delay_limit;

    assign item      = in.data;
    assign in.ready  = !out_valid_reg || out.ready;
    assign in_accept = in.valid && in.ready;
    assign cfg.ready = 1'b1;
    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

    assign enable    = item.enable_request || self_start_reg;
    assign go        = item.go_request || self_start_reg;
    assign count_inc = tick_counter_reg + 1'b1;
    assign ramp_sum  = {1'b0, ramp_reference_reg}
                     + {{(css_pkg::RefWidth + 1 - css_pkg::StepWidth){1'b0}}, ramp_step_reg};
    assign ramp_sat  = ramp_sum[css_pkg::RefWidth] ? {css_pkg::RefWidth{1'b1}}
                                                   : ramp_sum[css_pkg::RefWidth-1:0];
    assign delay_limit = (phase_reg == css_pkg::PH_GOOD_DELAY) ? power_good_delay_reg
                                                               : power_on_delay_reg;

    always_comb
    begin
        phase_next          = phase_reg;
        tick_counter_next   = tick_counter_reg;
        ramp_reference_next = ramp_reference_reg;
        pwm_drive_next      = pwm_drive_reg;
        loop_on_next        = loop_on_reg;
        ref_select_next     = ref_select_reg;
        status              = css_pkg::ST_OFF;

        // pulses first
        adc_active_next = adc_active_reg || item.adc_sample_seen;
        fault_flag_next = fault_flag_reg && !item.fault_clear;
        phase_cur       = item.fault_request ? css_pkg::PH_FAULT : phase_reg;

        unique case (phase_cur)
            css_pkg::PH_INIT:
            begin
                tick_counter_next   = '0;
                ramp_reference_next = '0;
                pwm_drive_next      = 1'b0;
                loop_on_next        = 1'b0;
                ref_select_next     = 1'b0;
                status              = css_pkg::ST_OFF;
                phase_next          = css_pkg::PH_LAUNCH;
            end
            css_pkg::PH_LAUNCH:
            begin
                status     = css_pkg::ST_OFF;
                phase_next = css_pkg::PH_STANDBY;
            end
            css_pkg::PH_STANDBY:
            begin
                status         = css_pkg::ST_STANDBY;
                pwm_drive_next = 1'b0;
                loop_on_next   = 1'b0;
                phase_next     = css_pkg::PH_STANDBY;
                if (enable && adc_active_next && !fault_flag_next && go)
                begin
                    tick_counter_next = '0;
                    phase_next        = css_pkg::PH_ON_DELAY;
                end
            end
            css_pkg::PH_ON_DELAY:
            begin
                status     = css_pkg::ST_START;
                phase_next = css_pkg::PH_ON_DELAY;
                // delay ends when the count before its increment exceeds the limit
                if (tick_counter_reg > delay_limit)
                begin
                    tick_counter_next   = '0;
                    ramp_reference_next = '0;
                    ref_select_next     = 1'b1;
                    phase_next          = css_pkg::PH_RAMP;
                end
                else
                begin
                    tick_counter_next = count_inc;
                end
            end
            css_pkg::PH_RAMP:
            begin
                status              = css_pkg::ST_START;
                pwm_drive_next      = 1'b1;
                loop_on_next        = 1'b1;
                ramp_reference_next = ramp_sat;
                phase_next          = css_pkg::PH_RAMP;
                if (ramp_sat >= {{(css_pkg::RefWidth - css_pkg::TargetWidth){1'b0}},
                                 item.target_reference})
                begin
                    tick_counter_next = '0;
                    phase_next        = css_pkg::PH_GOOD_DELAY;
                end
            end
            css_pkg::PH_GOOD_DELAY:
            begin
                status     = css_pkg::ST_START;
                phase_next = css_pkg::PH_GOOD_DELAY;
                if (tick_counter_reg > delay_limit)
                begin
                    tick_counter_next = '0;
                    phase_next        = css_pkg::PH_COMPLETE;
                end
                else
                begin
                    tick_counter_next = count_inc;
                end
            end
            css_pkg::PH_COMPLETE:
            begin
                status          = css_pkg::ST_ON;
                ref_select_next = 1'b0;
                phase_next      = css_pkg::PH_COMPLETE;
            end
            css_pkg::PH_FAULT:
            begin
                status          = css_pkg::ST_FAULT;
                fault_flag_next = 1'b1;
                adc_active_next = 1'b0;
                phase_next      = css_pkg::PH_STANDBY;
            end
            default:
            begin
                status     = css_pkg::ST_FAULT;
                phase_next = css_pkg::PH_STANDBY;
            end
        endcase

        out_data_next.run_status         = status;
        out_data_next.phase_now          = phase_next;
        out_data_next.pwm_output_enable  = pwm_drive_next;
        out_data_next.loop_enable        = loop_on_next;
        out_data_next.use_soft_reference = ref_select_next;
        out_data_next.soft_reference     = ramp_reference_next;
        out_data_next.fault_latched      = fault_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_delay_reg   <= css_pkg::PowerOnDelayReset;
            power_good_delay_reg <= css_pkg::PowerGoodDelayReset;
            ramp_step_reg        <= css_pkg::RampStepReset;
            self_start_reg       <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                css_pkg::REG_POWER_ON_DELAY:
                    power_on_delay_reg <= cfg.data.value[css_pkg::DelayWidth-1:0];
                css_pkg::REG_POWER_GOOD_DELAY:
                    power_good_delay_reg <= cfg.data.value[css_pkg::DelayWidth-1:0];
                css_pkg::REG_RAMP_STEP:
                    ramp_step_reg <= cfg.data.value[css_pkg::StepWidth-1:0];
                css_pkg::REG_SELF_START:
                    self_start_reg <= cfg.data.value[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= css_pkg::PH_INIT;
            tick_counter_reg   <= '0;
            ramp_reference_reg <= '0;
            fault_flag_reg     <= 1'b0;
            adc_active_reg     <= 1'b0;
            pwm_drive_reg      <= 1'b0;
            loop_on_reg        <= 1'b0;
            ref_select_reg     <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg          <= phase_next;
            tick_counter_reg   <= tick_counter_next;
            ramp_reference_reg <= ramp_reference_next;
            fault_flag_reg     <= fault_flag_next;
            adc_active_reg     <= adc_active_next;
            pwm_drive_reg      <= pwm_drive_next;
            loop_on_reg        <= loop_on_next;
            ref_select_reg     <= ref_select_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in.ready)
        begin
            out_valid_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire
